// ===== rtl/lrct_pkg.sv =====
// Shared types and constants for the LRU result cache table.
// Used by the cell row, the top level and the port checker; no dependencies.
package lrct_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int KEY_W        = 256;
	localparam int WORD_W       = 64;
	localparam int LEN_W        = 32;
	localparam int CTR_W        = 32;
	localparam int SLOT_W       = 4;
	localparam int LIMIT_W      = 5;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 5;

	// request kinds
	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// insert outcomes that may be cached
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_SMALL = 2'd1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b1;

	localparam logic               ENABLE_RST = 1'b1;
	localparam logic [LIMIT_W-1:0] LIMIT_RST  = 5'd16;

	// per-cell update commands
	localparam logic [1:0] OP_NONE   = 2'd0;
	localparam logic [1:0] OP_TOUCH  = 2'd1;
	localparam logic [1:0] OP_INSERT = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [WORD_W-1:0] key_word0;
		logic [WORD_W-1:0] key_word1;
		logic [WORD_W-1:0] key_word2;
		logic [WORD_W-1:0] key_word3;
		logic [1:0]        status_code;
		logic [LEN_W-1:0]  result_length;
		logic [LEN_W-1:0]  stored_length;
		logic [LEN_W-1:0]  buffer_length;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic              cached_status;
		logic [LEN_W-1:0]  true_length;
		logic [LEN_W-1:0]  copy_length;
		logic [SLOT_W-1:0] slot;
		logic              inserted;
		logic              evicted;
		logic [CTR_W-1:0]  hit_total;
		logic [CTR_W-1:0]  miss_total;
		logic [CTR_W-1:0]  insert_total;
		logic [CTR_W-1:0]  eviction_total;
	} rsp_t;

	// broadcast from the control stage to every cell
	typedef struct packed {
		logic [1:0]       op;
		logic [KEY_W-1:0] key;
		logic             status;
		logic [LEN_W-1:0] true_length;
		logic [LEN_W-1:0] kept_length;
	} cmd_t;

	// hit data passed down the row; at most one cell matches
	typedef struct packed {
		logic             found;
		logic             status;
		logic [LEN_W-1:0] true_length;
		logic [LEN_W-1:0] kept_length;
	} hit_data_t;

endpackage

// ===== rtl/lru_result_cache_table.sv =====
// Top level of the LRU result cache table: request staging, control stage,
// counters and the row of lrct_cell entries. Depends on lrct_pkg and lrct_cell.
//
//   port group  direction  handshake            payload
//   req         in         req_valid/req_ready  lrct_pkg::req_t
//   rsp         out        rsp_valid/rsp_ready  lrct_pkg::rsp_t
//   cfg         in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each request passes the compare stage, which compares the key in every cell and
// gathers the hit down the row, and then the control stage, which decides and
// updates ranks, slots and counters. A new request is taken as the previous
// one leaves the control stage, and never while one is in the compare stage.
// A full response register with rsp_ready low holds the control stage and blocks new requests.
// Reset empties the table and counters at once; no clearing pass.
module lru_result_cache_table #(
	parameter int CAPACITY = lrct_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  lrct_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output lrct_pkg::rsp_t                    rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lrct_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lrct_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import lrct_pkg::*;

	localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	function automatic logic [CTR_W-1:0] sat_add(input logic [CTR_W-1:0] a,
			input logic [CTR_W-1:0] b);
		logic [CTR_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[CTR_W] ? '1 : sum[CTR_W-1:0];
	endfunction

	logic                 valid_s1;
	req_t                 item_s1;
	logic                 valid_s2;
	req_t                 item_s2;
	hit_data_t            hit_s2;
	logic [RANK_W-1:0]    hit_rank_s2;
	logic [IDX_W-1:0]     hit_idx_s2;

	logic                 cache_enabled_q;
	logic [LIMIT_W-1:0]   entry_limit_q;
	logic [CNT_W-1:0]     count_q;
	logic [CTR_W-1:0]     hit_total_q;
	logic [CTR_W-1:0]     miss_total_q;
	logic [CTR_W-1:0]     insert_total_q;
	logic [CTR_W-1:0]     eviction_total_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	hit_data_t            hit_chain   [CAPACITY+1];
	logic [RANK_W-1:0]    rank_chain  [CAPACITY+1];
	logic [IDX_W-1:0]     idx_chain   [CAPACITY+1];
	logic                 taken_chain [CAPACITY+1];
	logic [IDX_W-1:0]     slot_chain  [CAPACITY+1];

	logic                 s2_go;
	logic                 acts_lookup;
	logic                 acts_insert;
	logic                 is_clear;
	logic [CNT_W-1:0]     lim_eff;
	logic                 over;
	logic [CNT_W-1:0]     evict_num;
	logic [1:0]           op_sel;
	cmd_t                 cmd;
	logic [RANK_W-1:0]    evict_rank;
	logic [CNT_W-1:0]     count_next;
	logic [CTR_W-1:0]     hit_total_next;
	logic [CTR_W-1:0]     miss_total_next;
	logic [CTR_W-1:0]     insert_total_next;
	logic [CTR_W-1:0]     eviction_total_next;
	rsp_t                 rsp_d;

	assign s2_go     = valid_s2 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 && (!valid_s2 || s2_go);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---- cell row ----
	assign hit_chain[0]   = '0;
	assign rank_chain[0]  = '0;
	assign idx_chain[0]   = '0;
	assign taken_chain[0] = 1'b0;
	assign slot_chain[0]  = '0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		lrct_cell #(
			.CAPACITY(CAPACITY),
			.INDEX(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.capture(valid_s1),
			.probe_key({item_s1.key_word3, item_s1.key_word2,
				item_s1.key_word1, item_s1.key_word0}),
			.cmd(cmd),
			.touch_rank(hit_rank_s2),
			.evict_rank(evict_rank),
			.hit_in(hit_chain[g]),
			.hit_out(hit_chain[g+1]),
			.rank_in(rank_chain[g]),
			.rank_out(rank_chain[g+1]),
			.idx_in(idx_chain[g]),
			.idx_out(idx_chain[g+1]),
			.taken_in(taken_chain[g]),
			.taken_out(taken_chain[g+1]),
			.slot_in(slot_chain[g]),
			.slot_out(slot_chain[g+1])
		);
	end

	// ---- control stage ----
	always_comb begin
		is_clear    = item_s2.kind == KIND_CLEAR;
		acts_lookup = (item_s2.kind == KIND_LOOKUP) && cache_enabled_q;
		acts_insert = (item_s2.kind == KIND_INSERT) && cache_enabled_q &&
			(item_s2.status_code == STATUS_OK || item_s2.status_code == STATUS_SMALL);

		if (entry_limit_q == '0 || int'(entry_limit_q) > CAPACITY) begin
			lim_eff = CNT_W'(CAPACITY);
		end else begin
			lim_eff = CNT_W'(entry_limit_q);
		end
		over       = count_q >= lim_eff;
		evict_num  = over ? CNT_W'(count_q - lim_eff + 1'b1) : '0;
		evict_rank = RANK_W'(lim_eff - 1'b1);

		if (is_clear) begin
			op_sel = OP_CLEAR;
		end else if ((acts_lookup || acts_insert) && hit_s2.found) begin
			op_sel = OP_TOUCH;
		end else if (acts_insert) begin
			op_sel = OP_INSERT;
		end else begin
			op_sel = OP_NONE;
		end

		cmd.op          = s2_go ? op_sel : OP_NONE;
		cmd.key         = {item_s2.key_word3, item_s2.key_word2,
			item_s2.key_word1, item_s2.key_word0};
		cmd.status      = item_s2.status_code[0];
		cmd.true_length = item_s2.result_length;
		cmd.kept_length = item_s2.stored_length;

		count_next          = count_q;
		hit_total_next      = hit_total_q;
		miss_total_next     = miss_total_q;
		insert_total_next   = insert_total_q;
		eviction_total_next = eviction_total_q;
		if (is_clear) begin
			count_next          = '0;
			hit_total_next      = '0;
			miss_total_next     = '0;
			insert_total_next   = '0;
			eviction_total_next = '0;
		end else if (acts_lookup) begin
			if (hit_s2.found) begin
				hit_total_next = sat_add(hit_total_q, CTR_W'(1));
			end else begin
				miss_total_next = sat_add(miss_total_q, CTR_W'(1));
			end
		end else if (op_sel == OP_INSERT) begin
			count_next          = over ? lim_eff : CNT_W'(count_q + 1'b1);
			insert_total_next   = sat_add(insert_total_q, CTR_W'(1));
			eviction_total_next = sat_add(eviction_total_q, CTR_W'(evict_num));
		end

		rsp_d = '0;
		if (acts_lookup && hit_s2.found) begin
			rsp_d.hit           = 1'b1;
			rsp_d.cached_status = hit_s2.status;
			rsp_d.true_length   = hit_s2.true_length;
			rsp_d.copy_length   = (hit_s2.kept_length < item_s2.buffer_length) ?
				hit_s2.kept_length : item_s2.buffer_length;
			rsp_d.slot          = SLOT_W'(hit_idx_s2);
		end else if (op_sel == OP_INSERT) begin
			rsp_d.slot     = SLOT_W'(slot_chain[CAPACITY]);
			rsp_d.inserted = 1'b1;
			rsp_d.evicted  = over;
		end
		rsp_d.hit_total      = hit_total_next;
		rsp_d.miss_total     = miss_total_next;
		rsp_d.insert_total   = insert_total_next;
		rsp_d.eviction_total = eviction_total_next;
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			rsp_valid_q      <= 1'b0;
			cache_enabled_q  <= ENABLE_RST;
			entry_limit_q    <= LIMIT_RST;
			count_q          <= '0;
			hit_total_q      <= '0;
			miss_total_q     <= '0;
			insert_total_q   <= '0;
			eviction_total_q <= '0;
		end else begin
			valid_s1 <= req_valid && req_ready;
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (s2_go) begin
				valid_s2 <= 1'b0;
			end

			if (s2_go) begin
				rsp_valid_q      <= 1'b1;
				count_q          <= count_next;
				hit_total_q      <= hit_total_next;
				miss_total_q     <= miss_total_next;
				insert_total_q   <= insert_total_next;
				eviction_total_q <= eviction_total_next;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ENABLE: cache_enabled_q <= cfg_data[0];
					CFG_LIMIT:  entry_limit_q   <= LIMIT_W'(cfg_data);
				endcase
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
		if (valid_s1) begin
			item_s2     <= item_s1;
			hit_s2      <= hit_chain[CAPACITY];
			hit_rank_s2 <= rank_chain[CAPACITY];
			hit_idx_s2  <= idx_chain[CAPACITY];
		end
		if (s2_go) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

// ===== rtl/lrct_cell.sv =====
// One table entry: key, outcome, lengths, valid and recency rank.
// Passes hit data and the free-slot token to its neighbor. Depends on lrct_pkg.
module lrct_cell #(
	parameter int CAPACITY = lrct_pkg::CAPACITY_DEF,
	parameter int INDEX = 0,
	localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         capture,
	input  logic [lrct_pkg::KEY_W-1:0]   probe_key,
	input  lrct_pkg::cmd_t               cmd,
	input  logic [RANK_W-1:0]            touch_rank,
	input  logic [RANK_W-1:0]            evict_rank,
	input  lrct_pkg::hit_data_t          hit_in,
	output lrct_pkg::hit_data_t          hit_out,
	input  logic [RANK_W-1:0]            rank_in,
	output logic [RANK_W-1:0]            rank_out,
	input  logic [IDX_W-1:0]             idx_in,
	output logic [IDX_W-1:0]             idx_out,
	input  logic                         taken_in,
	output logic                         taken_out,
	input  logic [IDX_W-1:0]             slot_in,
	output logic [IDX_W-1:0]             slot_out
);
	import lrct_pkg::*;

	logic              valid_q;
	logic [RANK_W-1:0] rank_q;
	logic [KEY_W-1:0]  key_q;
	logic              status_q;
	logic [LEN_W-1:0]  true_len_q;
	logic [LEN_W-1:0]  kept_len_q;
	logic              match_s2;
	logic              match;
	logic              evict_now;
	logic              free_now;
	logic              claim;

	assign match = valid_q && (key_q == probe_key);

	assign hit_out.found       = hit_in.found | match;
	assign hit_out.status      = hit_in.status | (match & status_q);
	assign hit_out.true_length = hit_in.true_length | ({LEN_W{match}} & true_len_q);
	assign hit_out.kept_length = hit_in.kept_length | ({LEN_W{match}} & kept_len_q);
	assign rank_out            = rank_in | ({RANK_W{match}} & rank_q);
	assign idx_out             = idx_in | (match ? IDX_W'(INDEX) : '0);

	// entries at or past the limit's oldest rank drop out on a new insert
	assign evict_now = valid_q && (rank_q >= evict_rank);
	assign free_now  = !valid_q || evict_now;
	assign claim     = (cmd.op == OP_INSERT) && free_now && !taken_in;
	assign taken_out = taken_in | free_now;
	assign slot_out  = claim ? IDX_W'(INDEX) : slot_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			rank_q   <= '0;
			match_s2 <= 1'b0;
		end else begin
			if (capture) begin
				match_s2 <= match;
			end
			case (cmd.op)
				OP_CLEAR: begin
					valid_q <= 1'b0;
					rank_q  <= '0;
				end
				OP_TOUCH: begin
					if (match_s2) begin
						rank_q <= '0;
					end else if (valid_q && rank_q < touch_rank) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				OP_INSERT: begin
					if (claim) begin
						valid_q <= 1'b1;
						rank_q  <= '0;
					end else if (evict_now) begin
						valid_q <= 1'b0;
						rank_q  <= '0;
					end else if (valid_q) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			key_q      <= cmd.key;
			status_q   <= cmd.status;
			true_len_q <= cmd.true_length;
			kept_len_q <= cmd.kept_length;
		end
	end

endmodule

// ===== rtl/lrct_checker.sv =====
// Port-level checks for lru_result_cache_table, bound to the top level.
// Depends on lrct_pkg; sees only the top level's ports.
module lrct_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input lrct_pkg::rsp_t                  rsp
);
	import lrct_pkg::*;

	// a stalled response transaction holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request in flight: no back-to-back acceptance
	a_req_gap: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted in consecutive cycles");

	a_hit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> !rsp.inserted && !rsp.evicted)
		else $error("hit reported together with an insert");

	a_evict_ins: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.evicted |-> rsp.inserted && rsp.eviction_total != '0)
		else $error("eviction without a new entry or count");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> rsp.hit_total != '0)
		else $error("hit reported with zero hit count");

endmodule

bind lru_result_cache_table lrct_checker u_lrct_checker (.*);
